/* rtl/ber_tlv_stream_parser_assert.svh */
// Assertion macros used by the BER-TLV stream parser top level.
`ifndef BER_TLV_STREAM_PARSER_ASSERT_SVH
`define BER_TLV_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bts_pkg.sv */
// Types and constants shared by the BER-TLV stream parser modules.
package bts_pkg;

    localparam logic [4:0]  TAG_EXT_CODE  = 5'h1F;
    localparam logic [7:0]  LEN_LONG_ONE  = 8'h81;
    localparam logic [7:0]  LEN_LONG_TWO  = 8'h82;
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_OVERRUN     = 2'd2;

    typedef enum logic [5:0] {
        PH_TAG_FIRST = 6'b000001,
        PH_TAG_NEXT  = 6'b000010,
        PH_LEN_FIRST = 6'b000100,
        PH_LEN_NEXT  = 6'b001000,
        PH_VALUE     = 6'b010000,
        PH_IDLE      = 6'b100000
    } t_phase;

    // Byte classification done by the front end.
    typedef struct packed {
        logic tag_more;   // low five bits all set
        logic hi_bit;     // bit 7 set
        logic long_form;  // one of the supported long length forms
    } t_byte_class;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        t_byte_class cls;
    } t_item;

    typedef struct packed {
        logic [23:0] tag_value;
        logic [1:0]  tag_bytes;
        logic [15:0] value_length;
        logic [15:0] element_offset;
        logic        is_outer;
        logic        last_element;
        logic [1:0]  status;
    } t_result;

endpackage

/* rtl/bts_if.sv */
// Stream interfaces for the input bytes and the parsed header results.
interface bts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bts_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] tag_value;
    logic [1:0]  tag_bytes;
    logic [15:0] value_length;
    logic [15:0] element_offset;
    logic        is_outer;
    logic        last_element;
    logic [1:0]  status;

    modport source (output valid, output tag_value, output tag_bytes, output value_length,
                    output element_offset, output is_outer, output last_element,
                    output status, input ready);
    modport sink   (input valid, input tag_value, input tag_bytes, input value_length,
                    input element_offset, input is_outer, input last_element,
                    input status, output ready);
endinterface

/* rtl/bts_front.sv */
// Front end: accepts bytes, classifies them and queues them for the parser.
module bts_front
    import bts_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bts_in_if.sink     i_in,
    output logic       o_item_valid,
    input  logic       i_item_ready,
    output t_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_queue [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_push;
    logic               w_pop;
    t_item              w_new;

    assign i_in.ready   = (r_count != CNT_W'(DEPTH));
    assign w_push       = i_in.valid && i_in.ready;
    assign o_item_valid = (r_count != '0);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item       = r_queue[r_rd_ptr];

    always_comb begin
        w_new.data_byte     = i_in.data_byte;
        w_new.first_byte    = i_in.first_byte;
        w_new.cls.tag_more  = (i_in.data_byte[4:0] == TAG_EXT_CODE);
        w_new.cls.hi_bit    = i_in.data_byte[7];
        w_new.cls.long_form = (i_in.data_byte == LEN_LONG_ONE) ||
                              (i_in.data_byte == LEN_LONG_TWO);
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_new;
        end
    end

endmodule

/* rtl/bts_back.sv */
// Back end: runs the TLV header state machine and holds the result register.
module bts_back
    import bts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_max_len,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    input  t_item       i_item,
    bts_out_if.source   o_out
);

    t_phase      r_phase,     c_phase,     n_phase;
    logic        r_outer,     c_outer,     n_outer;
    logic [23:0] r_tag,       c_tag,       n_tag;
    logic [1:0]  r_tag_cnt,   c_tag_cnt,   n_tag_cnt;
    logic [15:0] r_len,       c_len,       n_len;
    logic [1:0]  r_len_left,  c_len_left,  n_len_left;
    logic [16:0] r_offset,    c_offset,    n_offset;
    logic [15:0] r_elem,      c_elem,      n_elem;
    logic [15:0] r_outer_len, c_outer_len, n_outer_len;
    logic [15:0] r_val_left,  c_val_left,  n_val_left;

    logic        w_pop;
    logic        w_done;
    logic        w_bad;
    logic [17:0] w_end;
    logic [7:0]  w_b;
    t_result     w_res;
    t_result     r_out;
    logic        r_out_valid;

    assign o_item_ready = !r_out_valid || o_out.ready;
    assign w_pop        = i_item_valid && o_item_ready;
    assign w_b          = i_item.data_byte;

    always_comb begin
        // A restart byte sees the cleared parse state.
        if (i_item.first_byte) begin
            c_phase     = PH_TAG_FIRST;
            c_outer     = 1'b1;
            c_tag       = '0;
            c_tag_cnt   = '0;
            c_len       = '0;
            c_len_left  = '0;
            c_offset    = '0;
            c_elem      = '0;
            c_outer_len = '0;
            c_val_left  = '0;
        end else begin
            c_phase     = r_phase;
            c_outer     = r_outer;
            c_tag       = r_tag;
            c_tag_cnt   = r_tag_cnt;
            c_len       = r_len;
            c_len_left  = r_len_left;
            c_offset    = r_offset;
            c_elem      = r_elem;
            c_outer_len = r_outer_len;
            c_val_left  = r_val_left;
        end

        n_phase     = c_phase;
        n_outer     = c_outer;
        n_tag       = c_tag;
        n_tag_cnt   = c_tag_cnt;
        n_len       = c_len;
        n_len_left  = c_len_left;
        n_offset    = c_offset;
        n_elem      = c_elem;
        n_outer_len = c_outer_len;
        n_val_left  = c_val_left;
        w_done      = 1'b0;
        w_bad       = 1'b0;
        w_end       = '0;
        w_res       = '0;

        if (c_phase != PH_IDLE) begin
            if (!c_outer) begin
                if (c_phase == PH_TAG_FIRST) begin
                    n_elem = c_offset[15:0];
                end
                n_offset = c_offset + 17'd1;
            end

            unique case (c_phase)
                PH_TAG_FIRST: begin
                    n_tag      = {16'd0, w_b};
                    n_tag_cnt  = 2'd1;
                    n_len      = '0;
                    n_len_left = '0;
                    n_phase    = i_item.cls.tag_more ? PH_TAG_NEXT : PH_LEN_FIRST;
                end
                PH_TAG_NEXT: begin
                    n_tag     = {c_tag[15:0], w_b};
                    n_tag_cnt = c_tag_cnt + 2'd1;
                    // Only the second tag byte may ask for a third.
                    n_phase   = (c_tag_cnt == 2'd1 && w_b[7]) ? PH_TAG_NEXT : PH_LEN_FIRST;
                end
                PH_LEN_FIRST: begin
                    if (!i_item.cls.hi_bit) begin
                        n_len  = {8'd0, w_b};
                        w_done = 1'b1;
                    end else if (i_item.cls.long_form) begin
                        n_len      = '0;
                        n_len_left = w_b[1:0];
                        n_phase    = PH_LEN_NEXT;
                    end else begin
                        w_done = 1'b1;
                        w_bad  = 1'b1;
                    end
                end
                PH_LEN_NEXT: begin
                    n_len = {c_len[7:0], w_b};
                    if (c_len_left != 2'd0) begin
                        n_len_left = c_len_left - 2'd1;
                    end
                    if (n_len_left == 2'd0) begin
                        w_done = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (c_val_left != 16'd0) begin
                        n_val_left = c_val_left - 16'd1;
                    end
                    if (n_val_left == 16'd0) begin
                        n_phase = (n_offset >= {1'b0, c_outer_len}) ? PH_IDLE : PH_TAG_FIRST;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (w_done) begin
                w_end                = {1'b0, n_offset} + {2'b00, n_len};
                w_res.tag_value      = n_tag;
                w_res.tag_bytes      = n_tag_cnt;
                w_res.value_length   = n_len;
                w_res.element_offset = c_outer ? 16'd0 : n_elem;
                w_res.is_outer       = c_outer;
                if (w_bad) begin
                    w_res.value_length = '0;
                    w_res.last_element = 1'b1;
                    w_res.status       = ST_UNSUPPORTED;
                    n_phase            = PH_IDLE;
                end else if (c_outer) begin
                    if (n_len > i_max_len) begin
                        w_res.last_element = 1'b1;
                        w_res.status       = ST_OVERRUN;
                        n_phase            = PH_IDLE;
                    end else begin
                        w_res.last_element = (n_len == 16'd0);
                        w_res.status       = ST_OK;
                        n_outer_len        = n_len;
                        n_offset           = '0;
                        n_outer            = 1'b0;
                        n_phase            = (n_len == 16'd0) ? PH_IDLE : PH_TAG_FIRST;
                    end
                end else begin
                    if (w_end > {2'b00, c_outer_len}) begin
                        w_res.last_element = 1'b1;
                        w_res.status       = ST_OVERRUN;
                        n_phase            = PH_IDLE;
                    end else begin
                        w_res.last_element = (w_end == {2'b00, c_outer_len});
                        w_res.status       = ST_OK;
                        n_val_left         = n_len;
                        if (n_len != 16'd0) begin
                            n_phase = PH_VALUE;
                        end else begin
                            n_phase = w_res.last_element ? PH_IDLE : PH_TAG_FIRST;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG_FIRST;
            r_outer     <= 1'b1;
            r_tag       <= '0;
            r_tag_cnt   <= '0;
            r_len       <= '0;
            r_len_left  <= '0;
            r_offset    <= '0;
            r_elem      <= '0;
            r_outer_len <= '0;
            r_val_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase     <= n_phase;
                r_outer     <= n_outer;
                r_tag       <= n_tag;
                r_tag_cnt   <= n_tag_cnt;
                r_len       <= n_len;
                r_len_left  <= n_len_left;
                r_offset    <= n_offset;
                r_elem      <= n_elem;
                r_outer_len <= n_outer_len;
                r_val_left  <= n_val_left;
            end
            if (o_item_ready) begin
                r_out_valid <= w_pop && w_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_done) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.tag_value      = r_out.tag_value;
    assign o_out.tag_bytes      = r_out.tag_bytes;
    assign o_out.value_length   = r_out.value_length;
    assign o_out.element_offset = r_out.element_offset;
    assign o_out.is_outer       = r_out.is_outer;
    assign o_out.last_element   = r_out.last_element;
    assign o_out.status         = r_out.status;

endmodule

/* rtl/ber_tlv_stream_parser.sv */
// A finished header passes through the byte queue and the result register before it shows on the output.
// Throughput: one byte per cycle; the parser consumes one queued byte per cycle and
// stalls only while a finished result waits in the output register.
// The byte queue between front and back holds QUEUE_DEPTH entries.
// Reset (synchronous, active low) empties the queue, drops any result, sets the parser
// to expect an outer tag and loads the maximum outer length with 4096.
`include "ber_tlv_stream_parser_assert.svh"

// Top level of the BER-TLV stream parser.
module ber_tlv_stream_parser
    import bts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    bts_in_if.sink      i_in,
    bts_out_if.source   o_out
);

    logic [15:0] r_max_len;
    logic        w_item_valid;
    logic        w_item_ready;
    t_item       w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    bts_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    bts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_len    (r_max_len),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_out        (o_out)
    );

    // An error result always closes the message.
    `BTS_ASSERT_NOW(a_error_is_last, o_out.valid && (o_out.status != ST_OK), o_out.last_element, "error result without last_element")
    // The outer header always reports offset zero.
    `BTS_ASSERT_NOW(a_outer_offset, o_out.valid && o_out.is_outer, o_out.element_offset == 16'd0, "outer result with nonzero offset")
    // A result that is taken is not shown again unless the parser finished another header.
    `BTS_ASSERT_NEXT(a_no_repeat, o_out.valid && o_out.ready && !(w_item_valid && w_item_ready), !o_out.valid, "result repeated without a new transaction")

endmodule

/* tb/ber_tlv_stream_checker.sv */
// Checker that predicts the parsed BER-TLV headers and compares them with the parser output.
module ber_tlv_stream_checker
    import bts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    bts_in_if           i_in,
    bts_out_if          i_out,
    output int          o_fail_count,
    output int          o_pending
);

    logic [15:0] max_len;
    t_phase      phase;
    logic        outer_hdr;
    logic [23:0] tag_acc;
    logic [1:0]  tag_cnt;
    logic [15:0] len_acc;
    logic [1:0]  len_left;
    logic [16:0] offset;
    logic [15:0] elem_start;
    logic [15:0] outer_len;
    logic [15:0] value_left;
    t_result     expected_headers[$];

    task automatic restart_parse();
        phase      = PH_TAG_FIRST;
        outer_hdr  = 1'b1;
        tag_acc    = '0;
        tag_cnt    = '0;
        len_acc    = '0;
        len_left   = '0;
        offset     = '0;
        elem_start = '0;
        outer_len  = '0;
        value_left = '0;
    endtask

    // A header is complete (or carries a bad length form): queue its result and move on.
    task automatic close_header(input logic bad_form);
        t_result     hdr;
        logic [17:0] end_pos;
        hdr.tag_value      = tag_acc;
        hdr.tag_bytes      = tag_cnt;
        hdr.value_length   = len_acc;
        hdr.element_offset = outer_hdr ? 16'd0 : elem_start;
        hdr.is_outer       = outer_hdr;
        end_pos = {1'b0, offset} + {2'b00, len_acc};
        if (bad_form) begin
            hdr.value_length = '0;
            hdr.last_element = 1'b1;
            hdr.status       = ST_UNSUPPORTED;
            phase            = PH_IDLE;
        end else if (outer_hdr) begin
            if (len_acc > max_len) begin
                hdr.last_element = 1'b1;
                hdr.status       = ST_OVERRUN;
                phase            = PH_IDLE;
            end else begin
                hdr.last_element = (len_acc == 16'd0);
                hdr.status       = ST_OK;
                outer_len        = len_acc;
                offset           = '0;
                outer_hdr        = 1'b0;
                phase            = (len_acc == 16'd0) ? PH_IDLE : PH_TAG_FIRST;
            end
        end else if (end_pos > {2'b00, outer_len}) begin
            hdr.last_element = 1'b1;
            hdr.status       = ST_OVERRUN;
            phase            = PH_IDLE;
        end else begin
            hdr.last_element = (end_pos == {2'b00, outer_len});
            hdr.status       = ST_OK;
            value_left       = len_acc;
            if (len_acc != 16'd0) begin
                phase = PH_VALUE;
            end else begin
                phase = hdr.last_element ? PH_IDLE : PH_TAG_FIRST;
            end
        end
        expected_headers.push_back(hdr);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic restart);
        if (restart) begin
            restart_parse();
        end
        if (phase != PH_IDLE) begin
            // Offsets count only bytes inside the outer data.
            if (!outer_hdr) begin
                if (phase == PH_TAG_FIRST) begin
                    elem_start = offset[15:0];
                end
                offset = offset + 17'd1;
            end
            case (phase)
                PH_TAG_FIRST: begin
                    tag_acc  = {16'h0000, b};
                    tag_cnt  = 2'd1;
                    len_acc  = '0;
                    len_left = '0;
                    phase    = (b[4:0] == TAG_EXT_CODE) ? PH_TAG_NEXT : PH_LEN_FIRST;
                end
                PH_TAG_NEXT: begin
                    tag_acc = {tag_acc[15:0], b};
                    tag_cnt = tag_cnt + 2'd1;
                    phase   = (tag_cnt == 2'd2 && b[7]) ? PH_TAG_NEXT : PH_LEN_FIRST;
                end
                PH_LEN_FIRST: begin
                    if (!b[7]) begin
                        len_acc = {8'h00, b};
                        close_header(1'b0);
                    end else if (b == LEN_LONG_ONE || b == LEN_LONG_TWO) begin
                        len_acc  = '0;
                        len_left = b[1:0];
                        phase    = PH_LEN_NEXT;
                    end else begin
                        close_header(1'b1);
                    end
                end
                PH_LEN_NEXT: begin
                    len_acc = {len_acc[7:0], b};
                    if (len_left != 2'd0) begin
                        len_left = len_left - 2'd1;
                    end
                    if (len_left == 2'd0) begin
                        close_header(1'b0);
                    end
                end
                PH_VALUE: begin
                    if (value_left != 16'd0) begin
                        value_left = value_left - 16'd1;
                    end
                    if (value_left == 16'd0) begin
                        phase = (offset >= {1'b0, outer_len}) ? PH_IDLE : PH_TAG_FIRST;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            max_len      = MAX_LEN_RESET;
            o_fail_count = 0;
            restart_parse();
            expected_headers.delete();
        end else begin
            if (i_cfg_we) begin
                max_len = i_cfg_wdata;
            end
            // Results leave before bytes arrive, so the oldest expectation is checked first.
            if (i_out.valid && i_out.ready) begin
                seen.tag_value      = i_out.tag_value;
                seen.tag_bytes      = i_out.tag_bytes;
                seen.value_length   = i_out.value_length;
                seen.element_offset = i_out.element_offset;
                seen.is_outer       = i_out.is_outer;
                seen.last_element   = i_out.last_element;
                seen.status         = i_out.status;
                if (expected_headers.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: header with nothing expected: tag %h len %0d status %0d",
                                 $time, seen.tag_value, seen.value_length, seen.status);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_headers.pop_front();
                    if (seen !== want) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: header mismatch, expected tag %h/%0d len %0d off %0d %s",
                                     $time, want.tag_value, want.tag_bytes, want.value_length,
                                     want.element_offset,
                                     $sformatf("outer %b last %b status %0d", want.is_outer,
                                               want.last_element, want.status));
                            $display("%0t: header mismatch, actual   tag %h/%0d len %0d off %0d %s",
                                     $time, seen.tag_value, seen.tag_bytes, seen.value_length,
                                     seen.element_offset,
                                     $sformatf("outer %b last %b status %0d", seen.is_outer,
                                               seen.last_element, seen.status));
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                parse_byte(i_in.data_byte, i_in.first_byte);
            end
        end
        o_pending = expected_headers.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the BER-TLV stream parser testbench: clock, reset, byte stimulus and verdict.
module testbench;
    import bts_pkg::*;

    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          LONG_HOLD_CYCLES = 80;
    localparam int          SETTLE_CYCLES    = 6;
    // Indefinite length form, which the parser does not support.
    localparam logic [7:0]  LEN_NO_FORM      = 8'h80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          bytes_sent;
    logic [15:0] max_len_now;
    logic        burst_mode;
    logic        long_hold_req;
    logic [7:0]  stream[$];

    bts_in_if  in_bus ();
    bts_out_if out_bus ();

    ber_tlv_stream_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    ber_tlv_stream_checker header_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in         (in_bus),
        .i_out        (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random hold-off per transaction, and one long hold when requested.
    initial begin : result_sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (long_hold_req) begin
                gap           = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else begin
                gap = burst_mode ? 0 : $urandom_range(0, 3);
            end
            if (gap > 0) begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
            while (!out_bus.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic restart);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.data_byte  <= value;
        in_bus.first_byte <= restart;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        @(negedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // Sends n_send bytes of the stream starting at index split, wrapping around.
    task automatic send_stream(input int split, input int n_send);
        for (int k = 0; k < n_send; k++) begin
            send_byte(stream[(k + split) % stream.size()], k == 0);
        end
    endtask

    task automatic put_tag();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(1, 3);
        b    = 8'($urandom);
        if (kind == 1) begin
            if (b[4:0] == TAG_EXT_CODE) begin
                b[0] = 1'b0;
            end
            stream.push_back(b);
        end else begin
            b[4:0] = TAG_EXT_CODE;
            stream.push_back(b);
            b    = 8'($urandom);
            b[7] = (kind == 3);
            stream.push_back(b);
            if (kind == 3) begin
                b = 8'($urandom);
                stream.push_back(b);
            end
        end
    endtask

    task automatic put_length(input logic [15:0] len);
        int form;
        form = $urandom_range(0, 2);
        if (len > 16'd255) begin
            form = 2;
        end else if (len > 16'd127 && form == 0) begin
            form = 1;
        end
        case (form)
            0: begin
                stream.push_back(len[7:0]);
            end
            1: begin
                stream.push_back(LEN_LONG_ONE);
                stream.push_back(len[7:0]);
            end
            default: begin
                stream.push_back(LEN_LONG_TWO);
                stream.push_back(len[15:8]);
                stream.push_back(len[7:0]);
            end
        endcase
    endtask

    task automatic pause_input();
        in_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every expected header has come out and the byte queue has emptied.
    task automatic drain();
        pause_input();
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        max_len_now  = value;
    endtask

    task automatic run_phase(input int budget);
        int          start;
        int          pick;
        int          n_el;
        int          v;
        int          total;
        int          hdr;
        int          n_send;
        int          variant;
        int          cut;
        logic [15:0] olen;
        logic [7:0]  b;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            pick       = $urandom_range(0, 99);
            stream.delete();
            if (pick < 70) begin
                // Well-formed message, sometimes shortened, cut off or corrupted.
                n_el = $urandom_range(0, 4);
                repeat (n_el) begin
                    put_tag();
                    v = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 200)
                                                      : $urandom_range(0, 12);
                    put_length(16'(v));
                    repeat (v) begin
                        b = 8'($urandom);
                        stream.push_back(b);
                    end
                end
                total   = stream.size();
                variant = $urandom_range(0, 9);
                olen    = 16'(total);
                if (variant == 0 && total > 0) begin
                    olen = 16'(total - $urandom_range(1, (total < 3) ? total : 3));
                end
                put_tag();
                put_length(olen);
                hdr    = stream.size() - total;
                n_send = stream.size();
                if (variant == 1) begin
                    n_send = $urandom_range(1, n_send);
                end
                if (variant == 2) begin
                    b = 8'($urandom);
                    stream[$urandom_range(0, stream.size() - 1)] = b;
                end
                // The parser ignores the body of a message that is too long.
                if (olen > max_len_now) begin
                    cut = hdr + $urandom_range(0, 2);
                    if (cut < n_send) begin
                        n_send = cut;
                    end
                end
                send_stream(total, n_send);
            end else if (pick < 80) begin
                // Unsupported length form, in the outer header or in an inner element.
                put_tag();
                b = 8'($urandom_range(LEN_LONG_TWO, 8'hFF));
                if (b == LEN_LONG_TWO) begin
                    b = LEN_NO_FORM;
                end
                stream.push_back(b);
                if ($urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(0, 3)) begin
                        b = 8'($urandom);
                        stream.push_back(b);
                    end
                    total = stream.size();
                    put_tag();
                    put_length(16'(total + $urandom_range(0, 5)));
                    send_stream(total, stream.size());
                end else begin
                    send_stream(0, stream.size());
                end
            end else if (pick < 88 && max_len_now != 16'hFFFF) begin
                // Outer length above the limit, followed by bytes that are ignored.
                put_tag();
                stream.push_back(LEN_LONG_TWO);
                olen = 16'($urandom_range(max_len_now + 1, 16'hFFFF));
                stream.push_back(olen[15:8]);
                stream.push_back(olen[7:0]);
                repeat (2) begin
                    b = 8'($urandom);
                    stream.push_back(b);
                end
                send_stream(0, stream.size());
            end else begin
                n_el = $urandom_range(3, 10);
                for (int i = 0; i < n_el; i++) begin
                    b = 8'($urandom);
                    send_byte(b, i == 0 || $urandom_range(0, 15) == 0);
                end
            end
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_bus.valid      = 1'b0;
        in_bus.data_byte  = '0;
        in_bus.first_byte = 1'b0;
        out_bus.ready     = 1'b0;
        burst_mode        = 1'b0;
        long_hold_req     = 1'b0;
        bytes_sent        = 0;
        max_len_now       = MAX_LEN_RESET;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty outer data.
        stream = '{8'h70, 8'h00};
        send_stream(0, stream.size());
        // Three-byte outer tag with a two-byte length; inner elements in the one-byte
        // long form and with a zero length that ends exactly at the outer end.
        stream = '{8'hBF, 8'h81, 8'h01, 8'h82, 8'h00, 8'h07,
                   8'h5A, 8'h81, 8'h01, 8'hEE, 8'h5F, 8'h20, 8'h00};
        send_stream(0, stream.size());
        stream = '{8'h70, 8'hFF};
        send_stream(0, stream.size());
        // One byte above the limit after reset.
        stream = '{8'h70, 8'h82, 8'h10, 8'h01};
        send_stream(0, stream.size());
        // Restart in the middle of a message.
        stream = '{8'h70, 8'h05, 8'h5A};
        send_stream(0, stream.size());
        // Inner header that starts inside the outer data and ends past it.
        stream = '{8'h70, 8'h01, 8'h1F, 8'h20, 8'h00};
        send_stream(0, stream.size());

        write_max_len(16'h0000);
        run_phase(100);
        write_max_len(16'hFFFF);
        long_hold_req = 1'b1;
        run_phase(175);
        drain();
        run_phase(175);
        write_max_len(16'($urandom_range(4, 40)));
        run_phase(300);
        write_max_len(MAX_LEN_RESET);
        run_phase(250);
        write_max_len(16'($urandom));
        run_phase(250);

        drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
